// ----- hdl/bss_pkg.sv -----
// Shared types and codes for the bounded stack with search.
// No dependencies; imported by the entry RAM and the core.
`default_nettype none

package bss_pkg;

    localparam int WORD_W  = 32;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 3;
    localparam int LIMIT_W = 5;

    // Limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    // Strobes from the core to the entry RAM
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/bss_entry_ram.sv -----
// Entry store: one write port, one read port with registered read data.
// Depends on bss_pkg (word width, RAM control struct).
`default_nettype none

module bss_entry_ram
    import bss_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  wire logic              clk,
    input  wire ram_ctl_t          ctl,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [WORD_W-1:0] wr_data,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bounded_stack_with_search_core.sv -----
// Channel   | Handshake            | Word
// ----------+----------------------+-----------------------------------------------
// in        | in_valid / in_ready  | mode, value
// out       | out_valid / out_ready| status, top_value, fill_count, is_full, is_empty
// cfg       | cfg_wr_en            | cfg_wr_data (stack limit)
//
// One operation is in flight at a time. Push, mode 3, overflow, underflow and a pop
// that empties the stack go from idle straight to the finish state; a pop that
// leaves entries passes through a read state for the RAM read of the new top. A
// search reads at most fill_count entries, the single RAM read port walking one
// entry per cycle. The result sits in an output register, so a new word is taken
// while it waits. Reset clears the count and out_valid and sets the limit (16); the
// entry RAM is not cleared. A stalled output holds the core in its finish state.
// Depends on bss_pkg and bss_entry_ram.
`default_nettype none

module bounded_stack_with_search_core
    import bss_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_wr_en,
    input  wire logic [LIMIT_W-1:0]        cfg_wr_data,

    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [MODE_W-1:0]         mode,
    input  wire logic signed [WORD_W-1:0]  value,

    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [STAT_W-1:0]              status,
    output logic signed [WORD_W-1:0]       top_value,
    output logic [$clog2(DEPTH+1)-1:0]     fill_count,
    output logic                           is_full,
    output logic                           is_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Sequencer codes
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_POPRD  = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]         state_reg,  state_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [CNT_W-1:0]   ptr_reg,    ptr_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [WORD_W-1:0]  top_reg,    top_next;
    logic [WORD_W-1:0]  key_reg,    key_next;
    logic [STAT_W-1:0]  stat_reg,   stat_next;

    logic                     out_valid_reg;
    logic [STAT_W-1:0]        status_reg;
    logic signed [WORD_W-1:0] top_value_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic                     full_reg;
    logic                     empty_reg;

    ram_ctl_t          ram_ctl;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic [AW-1:0]     cnt_m2;

    logic [LW-1:0] lim_ext;
    logic [LW-1:0] lim_eff;
    logic [LW-1:0] cnt_ext;
    logic          in_fire;
    logic          out_free;

    bss_entry_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Effective limit saturates at the store depth
    assign lim_ext  = LW'(limit_reg);
    assign lim_eff  = (lim_ext > LW'(DEPTH)) ? LW'(DEPTH) : lim_ext;
    assign cnt_ext  = LW'(count_reg);
    assign cnt_m2   = AW'(count_reg - CNT_W'(2));

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Operation sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        top_next      = top_reg;
        key_next      = key_reg;
        stat_next     = stat_reg;
        ram_ctl.wr_en = 1'b0;
        ram_ctl.rd_en = 1'b0;
        rd_addr       = ptr_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    stat_next  = ST_OK;
                    state_next = S_FINISH;
                    case (mode)
                        MODE_PUSH:
                        begin
                            if (cnt_ext >= lim_eff)
                            begin
                                stat_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_ctl.wr_en = 1'b1;
                                top_next      = value;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                if (count_reg == CNT_W'(1))
                                begin
                                    top_next = '0;
                                end
                                else
                                begin
                                    // fetch the new top
                                    ram_ctl.rd_en = 1'b1;
                                    rd_addr       = cnt_m2;
                                    state_next    = S_POPRD;
                                end
                            end
                        end
                        MODE_SEARCH:
                        begin
                            key_next = value;
                            if (count_reg == '0)
                            begin
                                stat_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ram_ctl.rd_en = 1'b1;
                                rd_addr       = '0;
                                ptr_next      = CNT_W'(1);
                                state_next    = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            // unused code: report the stack as it is
                            stat_next = ST_OK;
                        end
                    endcase
                end
            end
            S_POPRD:
            begin
                top_next   = rd_data;
                state_next = S_FINISH;
            end
            S_SEARCH:
            begin
                // rd_data holds entry ptr_reg-1
                if (rd_data == key_reg)
                begin
                    stat_next  = ST_FOUND;
                    state_next = S_FINISH;
                end
                else if (ptr_reg == count_reg)
                begin
                    stat_next  = ST_NOT_FOUND;
                    state_next = S_FINISH;
                end
                else
                begin
                    ram_ctl.rd_en = 1'b1;
                    rd_addr       = ptr_reg[AW-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        top_reg  <= top_next;
        key_reg  <= key_next;
        stat_reg <= stat_next;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH && out_free)
        begin
            status_reg    <= stat_reg;
            top_value_reg <= (count_reg == '0) ? '0 : top_reg;
            fill_reg      <= count_reg;
            full_reg      <= (cnt_ext >= lim_eff);
            empty_reg     <= (count_reg == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign top_value  = top_value_reg;
    assign fill_count = fill_reg;
    assign is_full    = full_reg;
    assign is_empty   = empty_reg;

`ifndef SYNTH
    // Count never runs past the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // Scan pointer stays within the held entries
    a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (ptr_reg <= count_reg && ptr_reg != '0))
        else $error("search pointer out of range");

    // An accepted word always leaves idle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != S_IDLE))
        else $error("accepted word did not start");

    // Empty flag agrees with the reported count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (fill_count == '0)))
        else $error("empty flag disagrees with fill count");
`endif

endmodule

`default_nettype wire
